[design/fss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_pkg: shared constants for the same-sign float32 subtractor
// Field widths, special exponent codes, rounding constants and register map.
// ----------------------------------------------------------------------------
package fss_pkg;
  localparam logic [7:0]  EXP_MAX         = 8'hFF;
  localparam logic [30:0] HIDDEN_WIDE     = 31'h2000_0000;
  localparam logic [30:0] ROUND_HALF      = 31'h20;
  localparam logic [7:0]  MAX_ALIGN       = 8'd24;
  localparam logic [31:0] NAN_RESET       = 32'h7FC0_0001;
  localparam int          GUARD_BITS      = 6;
  localparam logic [1:0]  REG_DEFAULT_NAN = 2'd0;
endpackage

[design/float32_same_sign_subtract.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_same_sign_subtract: pipelined single-precision subtract
// Four register stages: order and align, subtract, normalize, round.
// ----------------------------------------------------------------------------
// Takes one request per cycle; busy is always low. Each difference appears
// on the difference port with done high, one result per request, in order,
// after passing through the four register stages: operand ordering and
// alignment, mantissa subtract, the leading-zero normalize shift, and the
// half-up rounding. The receiver cannot stall, so nothing is ever held back.
module float32_same_sign_subtract (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] minuend,
  input  logic [31:0] subtrahend,
  output logic        done,
  output logic [31:0] difference,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] default_nan;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == fss_pkg::REG_DEFAULT_NAN) ? default_nan : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      default_nan <= fss_pkg::NAN_RESET;
    end else if (psel && penable && pwrite && paddr == fss_pkg::REG_DEFAULT_NAN) begin
      default_nan <= pwdata;
    end
  end

  assign busy = 1'b0;

  // stage 1: order operands, settle special cases, align
  logic [7:0]  a_exp, b_exp, big_exp_c, small_exp_c, shift_c;
  logic [22:0] a_mant, b_mant, big_m_c, small_m_c;
  logic        b_big, sign_c, spec_c;
  logic [31:0] spec_w_c;
  logic [30:0] bigw_c, smallw_c;

  always_comb begin
    a_exp  = minuend[30:23];
    b_exp  = subtrahend[30:23];
    a_mant = minuend[22:0];
    b_mant = subtrahend[22:0];
    b_big  = (a_exp < b_exp) || (a_exp == b_exp && a_mant < b_mant);
    spec_c = 1'b0;
    spec_w_c = minuend;
    if (b_big) begin
      sign_c = ~minuend[31];
      big_exp_c = b_exp; big_m_c = b_mant;
      small_exp_c = a_exp; small_m_c = a_mant;
      shift_c = b_exp - a_exp;
      if (b_exp == fss_pkg::EXP_MAX) begin
        spec_c = 1'b1;
        spec_w_c = (b_mant != 23'd0) ? subtrahend : {~subtrahend[31], subtrahend[30:0]};
      end
    end else begin
      sign_c = minuend[31];
      big_exp_c = a_exp; big_m_c = a_mant;
      small_exp_c = b_exp; small_m_c = b_mant;
      shift_c = a_exp - b_exp;
      if (a_exp == fss_pkg::EXP_MAX) begin
        spec_c = 1'b1;
        spec_w_c = (a_mant == 23'd0 && b_exp == fss_pkg::EXP_MAX) ? default_nan : minuend;
      end
    end
    if (!spec_c && big_exp_c == 8'd0) begin
      spec_c = 1'b1;
      spec_w_c = {sign_c, 8'd0, big_m_c - small_m_c};
    end
    bigw_c = {2'b00, big_m_c, 6'd0} | fss_pkg::HIDDEN_WIDE;
    smallw_c = {2'b00, small_m_c, 6'd0};
    if (small_exp_c == 8'd0) shift_c = shift_c - 8'd1;
    else smallw_c = smallw_c | fss_pkg::HIDDEN_WIDE;
    if (shift_c <= fss_pkg::MAX_ALIGN) smallw_c = smallw_c >> shift_c[4:0];
    else smallw_c = 31'd0;
  end

  logic        v1, s1_sign, s1_spec;
  logic [7:0]  s1_exp;
  logic [30:0] s1_big, s1_small;
  logic [31:0] s1_word;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    s1_sign <= sign_c; s1_spec <= spec_c; s1_exp <= big_exp_c;
    s1_big <= bigw_c; s1_small <= smallw_c; s1_word <= spec_w_c;
  end

  // stage 2: subtract aligned mantissas
  logic        v2, s2_sign, s2_spec;
  logic [7:0]  s2_exp;
  logic [30:0] s2_m;
  logic [31:0] s2_word;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    s2_sign <= s1_sign; s2_spec <= s1_spec; s2_exp <= s1_exp;
    s2_m <= s1_big - s1_small; s2_word <= s1_word;
  end

  // stage 3: normalize left, stopping at the latest when the exponent reaches zero
  logic [4:0]  lz_c;
  logic [7:0]  sh_c;
  logic [30:0] norm_m_c;
  always_comb begin
    lz_c = 5'd30;
    for (int i = 0; i <= 29; i++) begin
      if (s2_m[i]) lz_c = 5'(29 - i);
    end
    sh_c = ({3'd0, lz_c} < s2_exp) ? {3'd0, lz_c} : s2_exp;
    // a zero difference drains the whole exponent
    if (s2_m == 31'd0) sh_c = s2_exp;
    norm_m_c = s2_m << sh_c[4:0];
  end

  logic        v3, s3_sign, s3_spec;
  logic [7:0]  s3_exp;
  logic [30:0] s3_m;
  logic [31:0] s3_word;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    s3_sign <= s2_sign; s3_spec <= s2_spec; s3_exp <= s2_exp - sh_c;
    s3_m <= norm_m_c; s3_word <= s2_word;
  end

  // stage 4: round half-up, renormalize on carry, pack
  logic [30:0] rnd_c;
  logic [7:0]  rexp_c;
  always_comb begin
    rnd_c = s3_m + fss_pkg::ROUND_HALF;
    rexp_c = s3_exp;
    if (rnd_c[30]) begin
      rexp_c = s3_exp + 8'd1;
      rnd_c = rnd_c >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v3;
    difference <= s3_spec ? s3_word
                : {s3_sign, rexp_c, rnd_c[fss_pkg::GUARD_BITS +: 23]};
  end

endmodule

[design/fss_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fss_checker: port-level checks for the float32 subtractor
// Latency, busy, reset and configuration port behavior.
// ----------------------------------------------------------------------------
module fss_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic        pready
);
  // every accepted request yields a result with done high
  a_lat: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##4 done) else $error("missing result");
  // no result without an earlier request
  a_noinv: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4)) else $error("spurious result");
  // the unit never refuses a request
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
  // no result right out of reset
  a_rst: assert property (@(posedge clk) rst |=> !done) else $error("done after reset");
  // the register port never waits
  a_rdy: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind float32_same_sign_subtract fss_checker u_fss_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .pready(pready)
);
